// ===== rtl/tasr_pkg.sv =====
// ----------------------------------------------------------------------------
// tasr_pkg
// Shared types and constants for the two-axis speed ramp controller.
// ----------------------------------------------------------------------------
`default_nettype none

package tasr_pkg;

  localparam int unsigned SPEED_W   = 16;
  localparam int unsigned MAXSPD_W  = 15;
  localparam int unsigned TMO_W     = 16;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned TDIV_W    = 4;
  localparam int unsigned NUM_AXES  = 2;

  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned IN_USER_W  = 3;
  localparam int unsigned OUT_DATA_W = 72;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic signed [SPEED_W-1:0] FIXED_STEP  = 16'sd100;
  localparam logic signed [SPEED_W-1:0] SPEED_LIMIT = 16'sd32767;
  localparam logic signed [SPEED_W-1:0] SPEED_MIN   = -16'sd32767;
  localparam logic signed [SPEED_W-1:0] SPEED_NEG_FULL = 16'sh8000;

  localparam logic [MAXSPD_W-1:0] SPD_LIM_RST    = 15'd1000;
  localparam logic [TMO_W-1:0]    TIMEOUT_MS_RST = 16'd200;

  typedef enum logic [1:0] {
    OP_NUDGE = 2'd0,
    OP_SET   = 2'd1,
    OP_TICK  = 2'd2
  } op_e;

  typedef enum logic {
    REG_SPD_LIM    = 1'b0,
    REG_TIMEOUT_MS = 1'b1
  } reg_e;

  typedef logic signed [SPEED_W-1:0] speed_t;

endpackage

`default_nettype wire

// ===== rtl/two_axis_speed_ramp.sv =====
// ----------------------------------------------------------------------------
// two_axis_speed_ramp
// Two-axis speed ramp controller with nudge, set-speed and tick commands and
// an auto-stop command timeout.
// ----------------------------------------------------------------------------
// One word is taken per clock cycle. Each word updates the axis state in a
// single pass of logic and its result lands in the output register in the next
// cycle; the input stays ready while that register is empty or is being
// drained, so throughput is one word per cycle unless the output side stalls.
// The speed limit sits at byte address 0 and timeout_ms at byte address 4 of
// the APB port; write them only while no word is in flight.
`default_nettype none

module two_axis_speed_ramp
  import tasr_pkg::*;
#(
  parameter int unsigned TICKS_PER_UPDATE = 9
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output      logic                  s_axis_tready,
  // amount[15:0], auto_stop[16], now_ms[48:17], zero pad [55:49]
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // operation[1:0], axis[2]
  input  wire logic [IN_USER_W-1:0]  s_axis_tuser,
  output      logic                  m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // speed_x[15:0], speed_y[31:16], target_x[47:32], target_y[63:48],
  // timed_out_x[64], timed_out_y[65], zero pad [71:66]
  output      logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output      logic [APB_DATA_W-1:0] prdata,
  output      logic                  pready
);

  localparam logic [TDIV_W-1:0] TICKS = TDIV_W'(TICKS_PER_UPDATE);

  logic [MAXSPD_W-1:0] spd_lim_q;
  logic [TMO_W-1:0]    timeout_ms_q;

  speed_t              cur_q  [NUM_AXES];
  speed_t              cur_d  [NUM_AXES];
  speed_t              tgt_q  [NUM_AXES];
  speed_t              tgt_d  [NUM_AXES];
  speed_t              step_q [NUM_AXES];
  speed_t              step_d [NUM_AXES];
  logic                as_q   [NUM_AXES];
  logic                as_d   [NUM_AXES];
  logic [TIME_W-1:0]   last_q [NUM_AXES];
  logic [TIME_W-1:0]   last_d [NUM_AXES];
  logic [TDIV_W-1:0]   tdiv_q;
  logic [TDIV_W-1:0]   tdiv_d;
  logic [TDIV_W-1:0]   tdiv_inc;
  logic                tmo    [NUM_AXES];

  logic                m_valid_q;
  logic [OUT_DATA_W-1:0] m_data_q;
  logic                in_fire;
  logic                cfg_wr;

  op_e                 op;
  logic                ax;
  speed_t              amount;
  logic                auto_stop;
  logic [TIME_W-1:0]   now_ms;

  logic signed [SPEED_W:0] nudge_sum;
  logic signed [SPEED_W:0] nudge_lim;
  speed_t                  nudge_tgt;
  speed_t                  set_tgt;

  function automatic speed_t ramp_f(speed_t cur, speed_t tgt, speed_t step);
    logic signed [SPEED_W:0] s;
    logic signed [SPEED_W:0] t;
    speed_t                  r;
    t = {tgt[SPEED_W-1], tgt};
    s = {cur[SPEED_W-1], cur} + {step[SPEED_W-1], step};
    if (cur == tgt) begin
      r = cur;
    end else if (tgt == '0) begin
      r = '0;
    end else begin
      if ((s < 0 && s < t) || (s > 0 && s > t)) begin
        s = t;
      end
      if (s > $signed({SPEED_LIMIT[SPEED_W-1], SPEED_LIMIT})) begin
        r = SPEED_LIMIT;
      end else if (s < $signed({SPEED_MIN[SPEED_W-1], SPEED_MIN})) begin
        r = SPEED_MIN;
      end else begin
        r = s[SPEED_W-1:0];
      end
    end
    return r;
  endfunction

  assign op        = op_e'(s_axis_tuser[1:0]);
  assign ax        = s_axis_tuser[2];
  assign amount    = s_axis_tdata[15:0];
  assign auto_stop = s_axis_tdata[16];
  assign now_ms    = s_axis_tdata[48:17];

  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_e'(paddr[2]))
      REG_SPD_LIM:    prdata = {{(APB_DATA_W-MAXSPD_W){1'b0}}, spd_lim_q};
      REG_TIMEOUT_MS: prdata = {{(APB_DATA_W-TMO_W){1'b0}}, timeout_ms_q};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spd_lim_q    <= SPD_LIM_RST;
      timeout_ms_q <= TIMEOUT_MS_RST;
    end else if (cfg_wr) begin
      case (reg_e'(paddr[2]))
        REG_SPD_LIM:    spd_lim_q    <= pwdata[MAXSPD_W-1:0];
        REG_TIMEOUT_MS: timeout_ms_q <= pwdata[TMO_W-1:0];
        default:        ;
      endcase
    end
  end

  // command datapath
  assign nudge_lim = {2'b00, spd_lim_q};
  assign nudge_sum = {tgt_q[ax][SPEED_W-1], tgt_q[ax]} + {amount[SPEED_W-1], amount};

  always_comb begin
    if (nudge_sum > nudge_lim) begin
      nudge_tgt = nudge_lim[SPEED_W-1:0];
    end else if (nudge_sum < -nudge_lim) begin
      nudge_tgt = SPEED_W'(-nudge_lim);
    end else begin
      nudge_tgt = nudge_sum[SPEED_W-1:0];
    end
  end

  assign set_tgt  = (amount == SPEED_NEG_FULL) ? SPEED_MIN : amount;
  assign tdiv_inc = tdiv_q + TDIV_W'(1);

  always_comb begin
    cur_d  = cur_q;
    tgt_d  = tgt_q;
    step_d = step_q;
    as_d   = as_q;
    last_d = last_q;
    tdiv_d = tdiv_q;
    for (int k = 0; k < NUM_AXES; k++) begin
      tmo[k] = 1'b0;
    end
    case (op)
      OP_NUDGE: begin
        as_d[ax]   = auto_stop;
        step_d[ax] = amount;
        tgt_d[ax]  = nudge_tgt;
        last_d[ax] = now_ms;
      end
      OP_SET: begin
        as_d[ax]   = 1'b0;
        step_d[ax] = FIXED_STEP;
        tgt_d[ax]  = set_tgt;
      end
      OP_TICK: begin
        for (int k = 0; k < NUM_AXES; k++) begin
          if (as_q[k] && tgt_q[k] != '0 &&
              (now_ms - last_q[k]) > {{(TIME_W-TMO_W){1'b0}}, timeout_ms_q}) begin
            tgt_d[k] = '0;
            tmo[k]   = 1'b1;
          end
        end
        tdiv_d = tdiv_inc;
        if (tdiv_inc >= TICKS) begin
          tdiv_d = '0;
          for (int k = 0; k < NUM_AXES; k++) begin
            cur_d[k] = ramp_f(cur_q[k], tgt_d[k], step_q[k]);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        cur_q[k]  <= '0;
        tgt_q[k]  <= '0;
        step_q[k] <= '0;
        as_q[k]   <= 1'b0;
        last_q[k] <= '0;
      end
      tdiv_q <= '0;
    end else if (in_fire) begin
      cur_q  <= cur_d;
      tgt_q  <= tgt_d;
      step_q <= step_d;
      as_q   <= as_d;
      last_q <= last_d;
      tdiv_q <= tdiv_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (in_fire) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      m_data_q <= {6'b000000, tmo[1], tmo[0], tgt_d[1], tgt_d[0], cur_d[1], cur_d[0]};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tasr_checker.sv =====
// ----------------------------------------------------------------------------
// tasr_checker
// Port-level checks for the two-axis speed ramp controller.
// ----------------------------------------------------------------------------
`default_nettype none

module tasr_checker
  import tasr_pkg::*;
(
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  s_axis_tvalid,
  input wire logic                  s_axis_tready,
  input wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  input wire logic [IN_USER_W-1:0]  s_axis_tuser,
  input wire logic                  m_axis_tvalid,
  input wire logic                  m_axis_tready,
  input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
  input wire logic                  psel,
  input wire logic                  penable,
  input wire logic                  pwrite,
  input wire logic [APB_ADDR_W-1:0] paddr,
  input wire logic [APB_DATA_W-1:0] pwdata,
  input wire logic [APB_DATA_W-1:0] prdata,
  input wire logic                  pready
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // every accepted word yields a result next cycle
  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted word produced no result");

  // empty output register never blocks input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // a timeout leaves a zero target
  a_timeout_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[64] || m_axis_tdata[65]) |->
      (!m_axis_tdata[64] || m_axis_tdata[47:32] == '0) &&
      (!m_axis_tdata[65] || m_axis_tdata[63:48] == '0))
    else $error("timed-out axis with nonzero target");

  // speeds stay within the symmetric limit
  a_speed_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[15:0] != SPEED_NEG_FULL &&
      m_axis_tdata[31:16] != SPEED_NEG_FULL)
    else $error("speed outside limit");

endmodule

bind two_axis_speed_ramp tasr_checker u_tasr_checker (.*);

`default_nettype wire

// ===== tb/two_axis_speed_ramp_test.sv =====
// ----------------------------------------------------------------------------
// two_axis_speed_ramp_test
// Self-checking bench for the two-axis speed ramp. A short directed table
// exercises extremes, every command and the timeout and ramp corner cases. It
// is followed by random nudge, set-speed, tick and unused-code words over
// several register settings and handshake profiles, including a long output
// stall. Results are checked against the table or an in-bench axis model.
// ----------------------------------------------------------------------------
module two_axis_speed_ramp_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tasr_pkg::*;

  localparam int unsigned TICKS_PER_UPDATE = 9;
  localparam int unsigned WATCHDOG_LIMIT   = 2000;
  localparam int unsigned HOLD_OFF_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES     = 8;
  localparam int unsigned ITEMS_PER_PHASE  = 255;
  localparam int unsigned MAX_REPORTS      = 100;
  localparam logic [1:0]  OP_NONE          = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic        axis;
    speed_t      amount;
    logic        auto_stop;
    logic [31:0] now_ms;
  } cmd_t;

  typedef struct packed {
    speed_t speed_x;
    speed_t speed_y;
    speed_t target_x;
    speed_t target_y;
    logic   timed_out_x;
    logic   timed_out_y;
  } axes_t;

  typedef struct packed {
    cmd_t  cmd;
    logic  typed;
    axes_t want;
  } row_t;

  localparam axes_t NO_CHECK = '0;

  localparam row_t DIRECTED [29] = '{
    '{'{OP_TICK,  1'b0, 16'sd0,         1'b0, 32'd0},          1'b1,
      '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0}},
    '{'{OP_NONE,  1'b1, 16'sd32767,     1'b1, 32'hFFFF_FFFF},  1'b1,
      '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b0}},
    '{'{OP_SET,   1'b0, SPEED_NEG_FULL, 1'b0, 32'd0},          1'b1,
      '{16'sd0, 16'sd0, -16'sd32767, 16'sd0, 1'b0, 1'b0}},
    '{'{OP_SET,   1'b1, 16'sd32767,     1'b0, 32'd0},          1'b1,
      '{16'sd0, 16'sd0, -16'sd32767, 16'sd32767, 1'b0, 1'b0}},
    '{'{OP_NUDGE, 1'b0, 16'sd32767,     1'b1, 32'd10},         1'b1,
      '{16'sd0, 16'sd0, 16'sd0, 16'sd32767, 1'b0, 1'b0}},
    '{'{OP_NUDGE, 1'b0, SPEED_NEG_FULL, 1'b1, 32'd20},         1'b1,
      '{16'sd0, 16'sd0, -16'sd1000, 16'sd32767, 1'b0, 1'b0}},
    '{'{OP_NUDGE, 1'b1, 16'sd5,         1'b0, 32'hFFFF_FFFF},  1'b1,
      '{16'sd0, 16'sd0, -16'sd1000, 16'sd1000, 1'b0, 1'b0}},
    '{'{OP_TICK,  1'b0, 16'sd0,         1'b0, 32'd220},        1'b0, NO_CHECK},
    '{'{OP_TICK,  1'b1, 16'sd0,         1'b0, 32'd221},        1'b0, NO_CHECK},
    '{'{OP_NUDGE, 1'b1, -16'sd3,        1'b1, 32'hFFFF_FF00},  1'b0, NO_CHECK},
    '{'{OP_TICK,  1'b0, 16'sd0,         1'b0, 32'h10},         1'b0, NO_CHECK},
    '{'{OP_SET,   1'b0, 16'sd300,       1'b1, 32'h10},         1'b0, NO_CHECK},
    '{'{OP_SET,   1'b1, -16'sd250,      1'b0, 32'h10},         1'b0, NO_CHECK},
    '{'{OP_TICK,  1'b0, 16'sd0,         1'b0, 32'h11},         1'b0, NO_CHECK},
    '{'{OP_TICK,  1'b0, 16'sd0,         1'b0, 32'h12},         1'b0, NO_CHECK},
    '{'{OP_TICK,  1'b0, 16'sd0,         1'b0, 32'h13},         1'b0, NO_CHECK},
    '{'{OP_TICK,  1'b0, 16'sd0,         1'b0, 32'h14},         1'b0, NO_CHECK},
    '{'{OP_TICK,  1'b0, 16'sd0,         1'b0, 32'h15},         1'b0, NO_CHECK},
    '{'{OP_NUDGE, 1'b0, SPEED_NEG_FULL, 1'b0, 32'd0},          1'b0, NO_CHECK},
    '{'{OP_SET,   1'b1, 16'sd0,         1'b0, 32'd0},          1'b0, NO_CHECK},
    '{'{OP_TICK,  1'b0, 16'sd0,         1'b1, 32'd1},          1'b0, NO_CHECK},
    '{'{OP_TICK,  1'b0, 16'sd0,         1'b0, 32'd2},          1'b0, NO_CHECK},
    '{'{OP_TICK,  1'b1, 16'sd0,         1'b0, 32'd3},          1'b0, NO_CHECK},
    '{'{OP_TICK,  1'b0, 16'sd0,         1'b0, 32'd4},          1'b0, NO_CHECK},
    '{'{OP_TICK,  1'b0, 16'sd0,         1'b0, 32'd5},          1'b0, NO_CHECK},
    '{'{OP_TICK,  1'b0, 16'sd0,         1'b0, 32'd6},          1'b0, NO_CHECK},
    '{'{OP_TICK,  1'b0, 16'sd0,         1'b0, 32'd7},          1'b0, NO_CHECK},
    '{'{OP_TICK,  1'b0, 16'sd0,         1'b0, 32'd8},          1'b0, NO_CHECK},
    '{'{OP_TICK,  1'b0, 16'sd0,         1'b0, 32'd9},          1'b0, NO_CHECK}
  };

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [IN_USER_W-1:0]  s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  psel          = 1'b0;
  logic                  penable       = 1'b0;
  logic                  pwrite        = 1'b0;
  logic [APB_ADDR_W-1:0] paddr         = '0;
  logic [APB_DATA_W-1:0] pwdata        = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // axis state mirror
  int          spd [2]      = '{0, 0};
  int          tgt [2]      = '{0, 0};
  int          stp [2]      = '{0, 0};
  logic        armed [2]    = '{1'b0, 1'b0};
  logic [31:0] cmd_time [2] = '{32'd0, 32'd0};
  int unsigned tick_cnt     = 0;
  int          max_spd      = int'(SPD_LIM_RST);
  logic [31:0] tmo_ms       = 32'(TIMEOUT_MS_RST);

  axes_t       pending_axes [$];
  logic [31:0] now_q         = '0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  bit          hold_req      = 1'b0;
  int unsigned hold_left     = 0;
  int unsigned idle_cycles   = 0;
  int unsigned mismatch_cnt  = 0;

  two_axis_speed_ramp #(
    .TICKS_PER_UPDATE(TICKS_PER_UPDATE)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int clamp_mag(int v, int lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic void ramp_axis(int a);
    int s;
    if (spd[a] == tgt[a]) return;
    if (tgt[a] == 0) begin
      spd[a] = 0;
      return;
    end
    s = spd[a] + stp[a];
    if ((s < 0 && s < tgt[a]) || (s > 0 && s > tgt[a])) s = tgt[a];
    spd[a] = clamp_mag(s, int'(SPEED_LIMIT));
  endfunction

  function automatic axes_t advance_axes(cmd_t c);
    axes_t r;
    int    a;
    r = '0;
    a = int'(c.axis);
    case (c.op)
      OP_NUDGE: begin
        armed[a]    = c.auto_stop;
        stp[a]      = int'(c.amount);
        tgt[a]      = clamp_mag(tgt[a] + int'(c.amount), max_spd);
        cmd_time[a] = c.now_ms;
      end
      OP_SET: begin
        armed[a] = 1'b0;
        stp[a]   = int'(FIXED_STEP);
        tgt[a]   = clamp_mag(int'(c.amount), int'(SPEED_LIMIT));
      end
      OP_TICK: begin
        for (int k = 0; k < 2; k++) begin
          if (armed[k] && tgt[k] != 0 && (c.now_ms - cmd_time[k]) > tmo_ms) begin
            tgt[k] = 0;
            if (k == 0) r.timed_out_x = 1'b1;
            else r.timed_out_y = 1'b1;
          end
        end
        tick_cnt = (tick_cnt + 1) & 4'hF;
        if (tick_cnt >= TICKS_PER_UPDATE) begin
          tick_cnt = 0;
          ramp_axis(0);
          ramp_axis(1);
        end
      end
      default: begin
      end
    endcase
    r.speed_x  = speed_t'(spd[0]);
    r.speed_y  = speed_t'(spd[1]);
    r.target_x = speed_t'(tgt[0]);
    r.target_y = speed_t'(tgt[1]);
    return r;
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t        c;
    int unsigned pick;
    int          lim;
    pick = $urandom_range(99);
    if (pick < 45) c.op = OP_TICK;
    else if (pick < 75) c.op = OP_NUDGE;
    else if (pick < 94) c.op = OP_SET;
    else c.op = OP_NONE;
    c.axis      = 1'($urandom);
    c.auto_stop = 1'($urandom);
    if ($urandom_range(49) == 0) now_q = $urandom();
    else now_q += $urandom_range(0, tmo_ms + tmo_ms / 2 + 3);
    c.now_ms = now_q;
    lim  = (max_spd < 4) ? 4 : max_spd;
    pick = $urandom_range(99);
    if (pick < 55) c.amount = speed_t'(int'($urandom_range(0, 2 * lim)) - lim);
    else if (pick < 80) c.amount = speed_t'(int'($urandom_range(0, 400)) - 200);
    else if (pick < 93) c.amount = speed_t'($urandom);
    else begin
      case ($urandom_range(3))
        0: c.amount = SPEED_LIMIT;
        1: c.amount = SPEED_NEG_FULL;
        2: c.amount = 16'sd0;
        default: c.amount = -16'sd1;
      endcase
    end
    return c;
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS) $display("%0t ns mismatch: %s", $time, msg);
  endtask

  task automatic check_field(string name, int got, int want_v);
    if (got != want_v) report_mismatch($sformatf("%s got %0d want %0d", name, got, want_v));
  endtask

  task automatic check_axes_word(logic [OUT_DATA_W-1:0] d);
    axes_t want;
    if (pending_axes.size() == 0) begin
      report_mismatch($sformatf("result word %h with nothing pending", d));
      return;
    end
    want = pending_axes.pop_front();
    check_field("speed_x", int'($signed(d[15:0])), int'(want.speed_x));
    check_field("speed_y", int'($signed(d[31:16])), int'(want.speed_y));
    check_field("target_x", int'($signed(d[47:32])), int'(want.target_x));
    check_field("target_y", int'($signed(d[63:48])), int'(want.target_y));
    check_field("timed_out_x", int'(d[64]), int'(want.timed_out_x));
    check_field("timed_out_y", int'(d[65]), int'(want.timed_out_y));
  endtask

  task automatic send_cmd(cmd_t c);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_DATA_W'({c.now_ms, c.auto_stop, c.amount});
    s_axis_tuser  <= {c.axis, c.op};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_axes.push_back(advance_axes(c));
  endtask

  task automatic write_reg(reg_e idx, logic [31:0] value);
    s_axis_tvalid <= 1'b0;
    while (pending_axes.size() != 0) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'(4 * int'(idx));
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_SPD_LIM) max_spd = int'(value[14:0]);
    else tmo_ms = {16'd0, value[15:0]};
  endtask

  task automatic run_phase(int unsigned mspd, int unsigned tmo, int unsigned s_idle,
                           int unsigned r_stall, bit pressure);
    write_reg(REG_SPD_LIM, mspd);
    write_reg(REG_TIMEOUT_MS, tmo);
    send_idle_pct = s_idle;
    stall_pct     = r_stall;
    if (pressure) hold_req = 1'b1;
    repeat (ITEMS_PER_PHASE) send_cmd(random_cmd());
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) check_axes_word(m_axis_tdata);
      if (hold_req) begin
        hold_left = HOLD_OFF_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("two_axis_speed_ramp regression: fail");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < $size(DIRECTED); i++) begin
      send_cmd(DIRECTED[i].cmd);
      if (DIRECTED[i].typed) pending_axes[pending_axes.size() - 1] = DIRECTED[i].want;
    end
    run_phase(32767, 0, 0, 0, 1'b0);
    run_phase(1, 65535, 53, 0, 1'b0);
    run_phase(0, 50, 0, 53, 1'b0);
    run_phase(500, 1000, 35, 35, 1'b0);
    run_phase(2000, 100, 0, 0, 1'b1);
    run_phase($urandom_range(1, 32767), $urandom_range(0, 65535), 35, 35, 1'b0);
    s_axis_tvalid <= 1'b0;
    while (pending_axes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("two_axis_speed_ramp regression: pass");
    end else begin
      $display("two_axis_speed_ramp regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/tasr_pkg.sv
rtl/two_axis_speed_ramp.sv
rtl/tasr_checker.sv
tb/two_axis_speed_ramp_test.sv
